[rtl/cgi_pkg.sv]
// ----------------------------------------------------------------------------
// cgi_pkg
// Shared types, constants and helpers of the circle gain interpolator.
// ----------------------------------------------------------------------------
package cgi_pkg;

    localparam int MaxPoints = 7;
    localparam int CountW    = 3;
    localparam int RadiusW   = 16;
    localparam int GainW     = 16;
    localparam int PointW    = RadiusW + 2 * GainW;
    localparam int ProdW     = 2 * GainW;
    localparam int StepW     = 5;
    localparam int CfgAddrW  = 3;

    localparam logic [CfgAddrW-1:0] RegCount = 3'd0;

    localparam logic [CountW-1:0] CountReset = 3'd7;
    localparam logic [GainW-1:0]  GainOne    = 16'h1000;
    localparam int RadiusBase = 300;
    localparam int RadiusStep = 50;

    typedef logic [MaxPoints-1:0][PointW-1:0] pts_t;

    typedef struct packed {
        logic load;
        logic step;
        logic take_cur;
        logic take_lo;
        logic take_zero;
        logic seg_load;
        logic mul;
        logic div_step;
        logic div_fin;
        logic out_load;
    } cgi_cmd_t;

    typedef struct packed {
        logic cnt_zero;
        logic first;
        logic at_end;
        logic le;
        logic out_free;
    } cgi_sts_t;

    function automatic pts_t reset_points();
        pts_t p;
        for (int i = 0; i < MaxPoints; i++) begin
            p[i] = {RadiusW'(RadiusBase + RadiusStep * i), GainOne, GainOne};
        end
        return p;
    endfunction

    localparam pts_t PtsReset = reset_points();

    function automatic logic [RadiusW-1:0] pt_radius(input logic [PointW-1:0] p);
        return p[PointW-1 -: RadiusW];
    endfunction

    function automatic logic [GainW-1:0] pt_left(input logic [PointW-1:0] p);
        return p[2*GainW-1 -: GainW];
    endfunction

    function automatic logic [GainW-1:0] pt_right(input logic [PointW-1:0] p);
        return p[GainW-1:0];
    endfunction

endpackage

[rtl/circle_gain_interpolator.sv]
// ----------------------------------------------------------------------------
// circle_gain_interpolator
// Piecewise linear lookup of left and right wheel gains from a turn radius
// over a table of up to seven calibration points.
//
//   channel  dir  handshake          payload
//   s_       in   s_tvalid/s_tready  s_tdata[15:0] radius
//   m_       out  m_tvalid/m_tready  m_tdata left/right gain, m_tuser valid
//   cfg_     in   cfg_we             cfg_addr, cfg_wdata
//
// An item that lands on an end point, or meets a table of zero points, ends
// with the scan, at one point per cycle; one inside a segment also takes a
// multiply, the one-bit-per-cycle divider over 32 quotient bits and one add.
// Reset is synchronous, active low, and restores the calibration table.
// The output register holds a finished beat while the next radius is taken;
// a stalled output holds the following result in the result registers.
// ----------------------------------------------------------------------------
module circle_gain_interpolator (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [15:0]                  s_tdata,   // [15:0] radius
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [31:0]                  m_tdata,   // [15:0] left gain, [31:16] right gain
    output logic                         m_tuser,   // [0] valid_res
    input  logic                         cfg_we,
    input  logic [cgi_pkg::CfgAddrW-1:0] cfg_addr,
    input  logic [cgi_pkg::PointW-1:0]   cfg_wdata
);
    import cgi_pkg::*;

    logic [CountW-1:0] count;
    pts_t              pts;
    cgi_cmd_t          cmd;
    cgi_sts_t          sts;
    logic [GainW-1:0]  gain_l, gain_r;

    cgi_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .count     (count),
        .pts       (pts)
    );

    cgi_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cgi_dpath u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .radius  (s_tdata),
        .count   (count),
        .pts     (pts),
        .cmd     (cmd),
        .sts     (sts),
        .m_ready (m_tready),
        .m_valid (m_tvalid),
        .m_left  (gain_l),
        .m_right (gain_r),
        .m_flag  (m_tuser)
    );

    assign m_tdata = {gain_r, gain_l};

`ifndef SYNTH
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("radius accepted while an item is in flight");

    a_zero_gains: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == 32'd0)
        else $error("invalid result carries nonzero gains");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> sts.out_free)
        else $error("output register overwritten before it was taken");
`endif

endmodule

[rtl/cgi_regs.sv]
// ----------------------------------------------------------------------------
// cgi_regs
// Configuration registers: point count and the packed calibration points.
// ----------------------------------------------------------------------------
module cgi_regs (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [cgi_pkg::CfgAddrW-1:0] cfg_addr,
    input  logic [cgi_pkg::PointW-1:0]   cfg_wdata,
    output logic [cgi_pkg::CountW-1:0]   count,
    output cgi_pkg::pts_t                pts
);
    import cgi_pkg::*;

    logic [CountW-1:0]   count_reg;
    pts_t                pts_reg;
    logic [CfgAddrW-1:0] slot;

    assign slot = cfg_addr - CfgAddrW'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= CountReset;
            pts_reg   <= PtsReset;
        end else if (cfg_we) begin
            if (cfg_addr == RegCount) begin
                count_reg <= cfg_wdata[CountW-1:0];
            end else begin
                pts_reg[slot] <= cfg_wdata;
            end
        end
    end

    assign count = count_reg;
    assign pts   = pts_reg;

endmodule

[rtl/cgi_ctrl.sv]
// ----------------------------------------------------------------------------
// cgi_ctrl
// Sequencer: segment scan, multiply, bit-serial divide, result hand-off.
// ----------------------------------------------------------------------------
module cgi_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  cgi_pkg::cgi_sts_t sts,
    output cgi_pkg::cgi_cmd_t cmd
);
    import cgi_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_FIX  = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [StepW-1:0] step_reg, step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (sts.cnt_zero) begin
                    cmd.take_zero = 1'b1;
                    state_next    = ST_FIN;
                end else if (sts.first && sts.le) begin
                    cmd.take_cur = 1'b1;
                    state_next   = ST_FIN;
                end else if (!sts.first && sts.at_end) begin
                    cmd.take_lo = 1'b1;
                    state_next  = ST_FIN;
                end else if (!sts.first && sts.le) begin
                    cmd.seg_load = 1'b1;
                    state_next   = ST_MUL;
                end else begin
                    cmd.step = 1'b1;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + StepW'(1);
                if (step_reg == '1) begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX: begin
                cmd.div_fin = 1'b1;
                state_next  = ST_FIN;
            end
            ST_FIN: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/cgi_dpath.sv]
// ----------------------------------------------------------------------------
// cgi_dpath
// Datapath: point scan registers, two gain lanes with multiplier and
// restoring divider, result and output registers.
// ----------------------------------------------------------------------------
module cgi_dpath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [cgi_pkg::RadiusW-1:0] radius,
    input  logic [cgi_pkg::CountW-1:0]  count,
    input  cgi_pkg::pts_t               pts,
    input  cgi_pkg::cgi_cmd_t           cmd,
    output cgi_pkg::cgi_sts_t           sts,
    input  logic                        m_ready,
    output logic                        m_valid,
    output logic [cgi_pkg::GainW-1:0]   m_left,
    output logic [cgi_pkg::GainW-1:0]   m_right,
    output logic                        m_flag
);
    import cgi_pkg::*;

    logic [RadiusW-1:0] r_reg;
    logic [CountW-1:0]  idx_reg;
    logic [PointW-1:0]  lo_reg;
    logic [PointW-1:0]  cur;

    logic [RadiusW-1:0] num_reg, den_reg;
    logic [GainW-1:0]   diff_l_reg, diff_r_reg;
    logic               up_l_reg, up_r_reg;
    logic [ProdW-1:0]   quo_l_reg, quo_r_reg;
    logic [GainW-1:0]   rem_l_reg, rem_r_reg;

    logic [GainW-1:0]   res_l_reg, res_r_reg;
    logic               res_v_reg;
    logic               out_v_reg;
    logic [GainW-1:0]   out_l_reg, out_r_reg;
    logic               out_f_reg;

    logic [GainW:0]     sh_l, sh_r;
    logic               ge_l, ge_r;
    logic [GainW-1:0]   lo_gl, lo_gr, cur_gl, cur_gr;

    assign cur    = (idx_reg < CountW'(MaxPoints)) ? pts[idx_reg] : '0;
    assign lo_gl  = pt_left(lo_reg);
    assign lo_gr  = pt_right(lo_reg);
    assign cur_gl = pt_left(cur);
    assign cur_gr = pt_right(cur);

    assign sts.cnt_zero = (count == '0);
    assign sts.first    = (idx_reg == '0);
    assign sts.at_end   = (idx_reg >= count);
    assign sts.le       = (r_reg <= pt_radius(cur));
    assign sts.out_free = !out_v_reg || m_ready;

    assign sh_l = {rem_l_reg, quo_l_reg[ProdW-1]};
    assign sh_r = {rem_r_reg, quo_r_reg[ProdW-1]};
    assign ge_l = (sh_l >= {1'b0, den_reg});
    assign ge_r = (sh_r >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            r_reg   <= radius;
            idx_reg <= '0;
        end else if (cmd.step) begin
            lo_reg  <= cur;
            idx_reg <= idx_reg + CountW'(1);
        end

        if (cmd.seg_load) begin
            num_reg    <= r_reg - pt_radius(lo_reg);
            den_reg    <= pt_radius(cur) - pt_radius(lo_reg);
            up_l_reg   <= (cur_gl >= lo_gl);
            up_r_reg   <= (cur_gr >= lo_gr);
            diff_l_reg <= (cur_gl >= lo_gl) ? cur_gl - lo_gl : lo_gl - cur_gl;
            diff_r_reg <= (cur_gr >= lo_gr) ? cur_gr - lo_gr : lo_gr - cur_gr;
        end

        if (cmd.mul) begin
            quo_l_reg <= diff_l_reg * num_reg;
            quo_r_reg <= diff_r_reg * num_reg;
            rem_l_reg <= '0;
            rem_r_reg <= '0;
        end else if (cmd.div_step) begin
            rem_l_reg <= ge_l ? GainW'(sh_l - {1'b0, den_reg}) : sh_l[GainW-1:0];
            rem_r_reg <= ge_r ? GainW'(sh_r - {1'b0, den_reg}) : sh_r[GainW-1:0];
            quo_l_reg <= {quo_l_reg[ProdW-2:0], ge_l};
            quo_r_reg <= {quo_r_reg[ProdW-2:0], ge_r};
        end

        if (cmd.take_zero) begin
            res_l_reg <= '0;
            res_r_reg <= '0;
            res_v_reg <= 1'b0;
        end else if (cmd.take_cur) begin
            res_l_reg <= cur_gl;
            res_r_reg <= cur_gr;
            res_v_reg <= 1'b1;
        end else if (cmd.take_lo) begin
            res_l_reg <= lo_gl;
            res_r_reg <= lo_gr;
            res_v_reg <= 1'b1;
        end else if (cmd.div_fin) begin
            res_l_reg <= up_l_reg ? lo_gl + quo_l_reg[GainW-1:0]
                                  : lo_gl - quo_l_reg[GainW-1:0];
            res_r_reg <= up_r_reg ? lo_gr + quo_r_reg[GainW-1:0]
                                  : lo_gr - quo_r_reg[GainW-1:0];
            res_v_reg <= 1'b1;
        end

        if (cmd.out_load) begin
            out_l_reg <= res_l_reg;
            out_r_reg <= res_r_reg;
            out_f_reg <= res_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_v_reg <= 1'b1;
        end else if (m_ready) begin
            out_v_reg <= 1'b0;
        end
    end

    assign m_valid = out_v_reg;
    assign m_left  = out_l_reg;
    assign m_right = out_r_reg;
    assign m_flag  = out_f_reg;

endmodule
